FILE: hw/rtl/i2cbb_pkg.sv
// Package for the I2C bit-bang master: phase and command codes, and the
// word, result and sequencer state types. No dependencies.
package i2cbb_pkg;

    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_WACK  = 3'd4;
    localparam logic [2:0] KIND_READ  = 3'd5;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ST_A    = 4'd1;
    localparam logic [3:0] PH_ST_B    = 4'd2;
    localparam logic [3:0] PH_SP_A    = 4'd3;
    localparam logic [3:0] PH_SP_B    = 4'd4;
    localparam logic [3:0] PH_SP_C    = 4'd5;
    localparam logic [3:0] PH_WR_SET  = 4'd6;
    localparam logic [3:0] PH_WR_HI   = 4'd7;
    localparam logic [3:0] PH_WR_LO   = 4'd8;
    localparam logic [3:0] PH_WA_A    = 4'd9;
    localparam logic [3:0] PH_WA_B    = 4'd10;
    localparam logic [3:0] PH_WA_POLL = 4'd11;
    localparam logic [3:0] PH_RD_LO   = 4'd12;
    localparam logic [3:0] PH_RD_HI   = 4'd13;
    localparam logic [3:0] PH_AK_LO   = 4'd14;
    localparam logic [3:0] PH_AK_HI   = 4'd15;

    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    localparam logic [7:0] HALF_PERIOD_RST = 8'd1;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] write_byte;
        logic       ack_after_read;
        logic       sda_level;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_missing;
    } t_res;

    typedef struct packed {
        logic [3:0] phase;
        logic [7:0] delay_count;
        logic [2:0] bit_count;
        logic [7:0] shift_reg;
        logic [7:0] poll_count;
        logic       scl_out;
        logic       sda_out;
        logic       ack_after_hold;
        logic [7:0] read_byte;
        logic       ack_fail;
        logic       stop_fail;
    } t_state;

endpackage

FILE: hw/rtl/i2cbb_in_if.sv
// Input channel of the I2C bit-bang master: one word per bus tick.
// Depends on nothing.
interface i2cbb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] write_byte;
    logic       ack_after_read;
    logic       sda_level;

    modport source (output valid, kind, write_byte, ack_after_read, sda_level,
                    input ready);
    modport sink (input valid, kind, write_byte, ack_after_read, sda_level,
                  output ready);
endinterface

FILE: hw/rtl/i2cbb_out_if.sv
// Result channel of the I2C bit-bang master: pin levels and status per tick.
// Depends on nothing.
interface i2cbb_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_missing;

    modport source (output valid, scl_level, sda_drive, busy_res, done_res,
                    read_data, ack_missing, input ready);
    modport sink (input valid, scl_level, sda_drive, busy_res, done_res,
                  read_data, ack_missing, output ready);
endinterface

FILE: hw/rtl/i2c_bitbang_master_unit.sv
// Top level of the I2C bit-bang master: input word register, sequencer step
// and result register. Depends on i2cbb_pkg, i2cbb_in_if, i2cbb_out_if, i2cbb_step.
// An accepted word passes through the input word register, then the result register.
// Throughput is one word per cycle while the result channel does not stall; the sequencer state advances once per word.
// Reset is synchronous and active low; it empties both registers, returns the
// sequencer to idle with both lines released and restores the register defaults.
module i2c_bitbang_master_unit
    import i2cbb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cbb_in_if.sink    i_in,
    i2cbb_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    logic       r_s1_valid;
    t_item      r_s1_item;
    logic       r_out_valid;
    t_res       r_out;
    t_state     r_st;
    logic [7:0] r_half_period;
    logic [7:0] r_ack_timeout;
    t_state     n_st;
    t_res       n_res;
    logic       s1_adv;
    logic       in_ready;

    assign s1_adv   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_s1_valid || s1_adv;
    assign i_in.ready = in_ready;

    i2cbb_step u_step (
        .i_state       (r_st),
        .i_item        (r_s1_item),
        .i_half_period (r_half_period),
        .i_ack_timeout (r_ack_timeout),
        .o_state       (n_st),
        .o_res         (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_s1_item.kind           <= i_in.kind;
            r_s1_item.write_byte     <= i_in.write_byte;
            r_s1_item.ack_after_read <= i_in.ack_after_read;
            r_s1_item.sda_level      <= i_in.sda_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase          <= PH_IDLE;
            r_st.delay_count    <= 8'd0;
            r_st.bit_count      <= 3'd0;
            r_st.shift_reg      <= 8'd0;
            r_st.poll_count     <= 8'd0;
            r_st.scl_out        <= 1'b1;
            r_st.sda_out        <= 1'b1;
            r_st.ack_after_hold <= 1'b0;
            r_st.read_byte      <= 8'd0;
            r_st.ack_fail       <= 1'b0;
            r_st.stop_fail      <= 1'b0;
        end else if (s1_adv) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HALF_PERIOD: r_half_period <= i_cfg_data;
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.scl_level   = r_out.scl_level;
    assign o_out.sda_drive   = r_out.sda_drive;
    assign o_out.busy_res    = r_out.busy_res;
    assign o_out.done_res    = r_out.done_res;
    assign o_out.read_data   = r_out.read_data;
    assign o_out.ack_missing = r_out.ack_missing;

    a_idle_no_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.phase == PH_IDLE) |-> (r_st.delay_count == 8'd0))
        else $error("Delay count left non-zero in idle.");

    a_stop_fail_in_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.stop_fail |-> (r_st.phase == PH_SP_A || r_st.phase == PH_SP_B ||
                            r_st.phase == PH_SP_C))
        else $error("Timeout flag set outside the stop sequence.");

    a_stall_holds_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (r_s1_valid && r_out_valid && !o_out.ready))
        else $error("Input stalled without a full pipeline.");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && n_res.done_res) |=> (r_st.phase == PH_IDLE && !r_out.busy_res))
        else $error("Finished command left the sequencer busy.");

endmodule

FILE: hw/rtl/i2cbb_step.sv
// Next-state and result logic of the I2C bit-bang sequencer for one tick.
// Depends on i2cbb_pkg.
module i2cbb_step
    import i2cbb_pkg::*;
(
    input  t_state     i_state,
    input  t_item      i_item,
    input  logic [7:0] i_half_period,
    input  logic [7:0] i_ack_timeout,
    output t_state     o_state,
    output t_res       o_res
);

    t_state     n_st;
    logic       done;
    logic [7:0] hold_cnt;

    assign hold_cnt = (i_half_period == 8'd0) ? 8'd0 : i_half_period - 8'd1;

    always_comb begin
        n_st = i_state;
        done = 1'b0;
        if (i_state.phase == PH_IDLE) begin
            unique case (i_item.kind)
                KIND_START: begin
                    n_st.scl_out = 1'b1;
                    n_st.sda_out = 1'b1;
                    n_st.phase = PH_ST_A;
                    n_st.delay_count = hold_cnt;
                end
                KIND_STOP: begin
                    n_st.scl_out = 1'b0;
                    n_st.sda_out = 1'b0;
                    n_st.phase = PH_SP_A;
                    n_st.delay_count = hold_cnt;
                end
                KIND_WRITE: begin
                    n_st.scl_out = 1'b0;
                    n_st.shift_reg = i_item.write_byte;
                    n_st.bit_count = 3'd0;
                    n_st.sda_out = i_item.write_byte[7];
                    n_st.phase = PH_WR_SET;
                    n_st.delay_count = hold_cnt;
                end
                KIND_WACK: begin
                    n_st.sda_out = 1'b1;
                    n_st.poll_count = 8'd0;
                    n_st.ack_fail = 1'b0;
                    n_st.stop_fail = 1'b0;
                    n_st.phase = PH_WA_A;
                    n_st.delay_count = hold_cnt;
                end
                KIND_READ: begin
                    n_st.sda_out = 1'b1;
                    n_st.scl_out = 1'b0;
                    n_st.shift_reg = 8'd0;
                    n_st.bit_count = 3'd0;
                    n_st.ack_after_hold = i_item.ack_after_read;
                    n_st.phase = PH_RD_LO;
                    n_st.delay_count = hold_cnt;
                end
                default: begin
                end
            endcase
        end else if (i_state.phase != PH_WA_POLL && i_state.delay_count != 8'd0) begin
            n_st.delay_count = i_state.delay_count - 8'd1;
        end else begin
            unique case (i_state.phase)
                PH_ST_A: begin
                    n_st.sda_out = 1'b0;
                    n_st.phase = PH_ST_B;
                    n_st.delay_count = hold_cnt;
                end
                PH_SP_A: begin
                    n_st.scl_out = 1'b1;
                    n_st.phase = PH_SP_B;
                    n_st.delay_count = hold_cnt;
                end
                PH_SP_B: begin
                    n_st.sda_out = 1'b1;
                    n_st.phase = PH_SP_C;
                    n_st.delay_count = hold_cnt;
                end
                PH_SP_C: begin
                    if (i_state.stop_fail) begin
                        n_st.ack_fail = 1'b1;
                        n_st.stop_fail = 1'b0;
                    end
                    n_st.phase = PH_IDLE;
                    n_st.delay_count = 8'd0;
                    done = 1'b1;
                end
                PH_WR_SET: begin
                    n_st.scl_out = 1'b1;
                    n_st.phase = PH_WR_HI;
                    n_st.delay_count = hold_cnt;
                end
                PH_WR_HI: begin
                    n_st.scl_out = 1'b0;
                    n_st.phase = PH_WR_LO;
                    n_st.delay_count = hold_cnt;
                end
                PH_WR_LO: begin
                    if (i_state.bit_count == 3'd7) begin
                        n_st.phase = PH_IDLE;
                        n_st.delay_count = 8'd0;
                        done = 1'b1;
                    end else begin
                        n_st.bit_count = i_state.bit_count + 3'd1;
                        n_st.shift_reg = {i_state.shift_reg[6:0], 1'b0};
                        n_st.sda_out = i_state.shift_reg[6];
                        n_st.phase = PH_WR_SET;
                        n_st.delay_count = hold_cnt;
                    end
                end
                PH_WA_A: begin
                    n_st.scl_out = 1'b1;
                    n_st.phase = PH_WA_B;
                    n_st.delay_count = hold_cnt;
                end
                PH_WA_B, PH_WA_POLL: begin
                    n_st.phase = PH_WA_POLL;
                    n_st.delay_count = 8'd0;
                    if (!i_item.sda_level) begin
                        n_st.scl_out = 1'b0;
                        n_st.phase = PH_IDLE;
                        done = 1'b1;
                    end else if (i_state.poll_count >= i_ack_timeout) begin
                        n_st.stop_fail = 1'b1;
                        n_st.scl_out = 1'b0;
                        n_st.sda_out = 1'b0;
                        n_st.phase = PH_SP_A;
                        n_st.delay_count = hold_cnt;
                    end else begin
                        n_st.poll_count = i_state.poll_count + 8'd1;
                    end
                end
                PH_RD_LO: begin
                    n_st.scl_out = 1'b1;
                    n_st.shift_reg = {i_state.shift_reg[6:0], i_item.sda_level};
                    n_st.phase = PH_RD_HI;
                    n_st.delay_count = hold_cnt;
                end
                PH_RD_HI: begin
                    n_st.scl_out = 1'b0;
                    if (i_state.bit_count == 3'd7) begin
                        n_st.sda_out = ~i_state.ack_after_hold;
                        n_st.phase = PH_AK_LO;
                    end else begin
                        n_st.bit_count = i_state.bit_count + 3'd1;
                        n_st.phase = PH_RD_LO;
                    end
                    n_st.delay_count = hold_cnt;
                end
                PH_AK_LO: begin
                    n_st.scl_out = 1'b1;
                    n_st.phase = PH_AK_HI;
                    n_st.delay_count = hold_cnt;
                end
                PH_AK_HI: begin
                    n_st.scl_out = 1'b0;
                    n_st.read_byte = i_state.shift_reg;
                    n_st.phase = PH_IDLE;
                    n_st.delay_count = 8'd0;
                    done = 1'b1;
                end
                default: begin
                    n_st.scl_out = (i_state.phase == PH_ST_B) ? 1'b0 : i_state.scl_out;
                    n_st.phase = PH_IDLE;
                    n_st.delay_count = 8'd0;
                    done = 1'b1;
                end
            endcase
        end
    end

    assign o_state = n_st;

    always_comb begin
        o_res.scl_level   = n_st.scl_out;
        o_res.sda_drive   = n_st.sda_out;
        o_res.busy_res    = (n_st.phase != PH_IDLE);
        o_res.done_res    = done;
        o_res.read_data   = n_st.read_byte;
        o_res.ack_missing = n_st.ack_fail;
    end

endmodule
